// ===== hdl/png_row_unfilter_core_defines.svh =====
// ----------------------------------------------------------------------------
// png_row_unfilter_core_defines.svh
// Assertion macros for the PNG row unfilter core. They expand to concurrent
// assertions in simulation and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PNG_ROW_UNFILTER_CORE_DEFINES_SVH
`define PNG_ROW_UNFILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset
`define PUC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included
`define PUC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PUC_ASSERT(label, prop, msg)
`define PUC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hdl/png_unf_pkg.sv =====
// ----------------------------------------------------------------------------
// png_unf_pkg
// Shared widths, register indexes, filter codes and the per-byte operation
// record passed from the front end to the reconstruction back end.
// ----------------------------------------------------------------------------
`default_nettype none

package png_unf_pkg;

  localparam int DATA_W         = 8;
  localparam int ROW_BYTES_W    = 14;
  localparam int PIXEL_STRIDE_W = 4;
  localparam int CFG_DATA_W     = 14;
  localparam int CFG_INDEX_W    = 1;

  // Defaults for the top-level parameters
  localparam int MAX_ROW_BYTES_DEF   = 8192;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  // Depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_STRIDE = 1'd1;

  // Reset values of the configuration registers
  localparam logic [ROW_BYTES_W-1:0]    ROW_BYTES_RST    = 14'd4;
  localparam logic [PIXEL_STRIDE_W-1:0] PIXEL_STRIDE_RST = 4'd4;

  // Filter types
  localparam logic [DATA_W-1:0] FILT_NONE  = 8'd0;
  localparam logic [DATA_W-1:0] FILT_SUB   = 8'd1;
  localparam logic [DATA_W-1:0] FILT_UP    = 8'd2;
  localparam logic [DATA_W-1:0] FILT_AVG   = 8'd3;
  localparam logic [DATA_W-1:0] FILT_PAETH = 8'd4;

  // One classified data byte
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] filter;
    logic              left_ok;   // column is past the first pixel
    logic              first_row; // no row above
    logic              row_end;   // last byte of its row
  } unf_op_t;

endpackage

`default_nettype wire

// ===== hdl/png_unf_in_if.sv =====
// ----------------------------------------------------------------------------
// png_unf_in_if
// Input stream: filtered image bytes with an image start marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface png_unf_in_if;
  logic                                valid;
  logic                                ready;
  logic [png_unf_pkg::DATA_W-1:0]      data_byte;
  logic                                image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

`default_nettype wire

// ===== hdl/png_unf_out_if.sv =====
// ----------------------------------------------------------------------------
// png_unf_out_if
// Output stream: reconstructed image bytes with an end of row flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface png_unf_out_if;
  logic                                valid;
  logic                                ready;
  logic [png_unf_pkg::DATA_W-1:0]      pixel_byte;
  logic                                row_end;

  modport source (output valid, output pixel_byte, output row_end, input ready);
  modport sink   (input valid, input pixel_byte, input row_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/png_unf_ram.sv =====
// ----------------------------------------------------------------------------
// png_unf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module png_unf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/png_unf_fifo.sv =====
// ----------------------------------------------------------------------------
// png_unf_fifo
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module png_unf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] rdata,
  output      logic             valid,
  output      logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign valid = (count != '0);
  assign full  = (count == CW'(DEPTH));
  assign rdata = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/png_unf_front.sv =====
// ----------------------------------------------------------------------------
// png_unf_front
// Front end: tracks row position, separates filter bytes from data bytes and
// tags each data byte with its column, filter and neighbour availability.
// ----------------------------------------------------------------------------
`default_nettype none

module png_unf_front #(
  parameter int MAX_ROW_BYTES   = png_unf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = png_unf_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic [png_unf_pkg::ROW_BYTES_W-1:0]     row_bytes,
  input  wire logic [png_unf_pkg::PIXEL_STRIDE_W-1:0]  pixel_stride,
  input  wire logic                                    take,
  input  wire logic [png_unf_pkg::DATA_W-1:0]          data_byte,
  input  wire logic                                    image_start,
  output      logic                                    push,
  output      logic [$clog2(MAX_ROW_BYTES)-1:0]        push_col,
  output      png_unf_pkg::unf_op_t                    push_op,
  output      logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] pb_idx
);

  localparam int AW   = $clog2(MAX_ROW_BYTES);
  localparam int RBW  = $clog2(MAX_ROW_BYTES + 1);
  localparam int CMPW = (RBW > png_unf_pkg::ROW_BYTES_W) ? RBW : png_unf_pkg::ROW_BYTES_W;
  localparam int PIW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int PBW  = png_unf_pkg::PIXEL_STRIDE_W;

  logic [AW-1:0]                     column_count;
  logic [png_unf_pkg::DATA_W-1:0]    row_filter;
  logic                              awaiting_filter;
  logic                              on_first_row;

  logic [CMPW-1:0] rb_eff;
  logic [PBW-1:0]  pb_eff;
  logic [CMPW-1:0] col_inc;
  logic            is_filter;
  logic            row_end;
  logic            left_ok;

  // Clamp the configuration into its legal range
  always_comb begin
    if (row_bytes == '0) begin
      rb_eff = CMPW'(1);
    end else if (CMPW'(row_bytes) > CMPW'(MAX_ROW_BYTES)) begin
      rb_eff = CMPW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = CMPW'(row_bytes);
    end
    if (pixel_stride == '0) begin
      pb_eff = PBW'(1);
    end else if (pixel_stride > PBW'(MAX_PIXEL_BYTES)) begin
      pb_eff = PBW'(MAX_PIXEL_BYTES);
    end else begin
      pb_eff = pixel_stride;
    end
  end

  assign pb_idx = PIW'(pb_eff - PBW'(1));

  // Classify the beat
  assign is_filter = image_start || awaiting_filter;
  assign col_inc   = CMPW'(column_count) + CMPW'(1);
  assign row_end   = (col_inc >= rb_eff);
  assign left_ok   = (CMPW'(column_count) >= CMPW'(pb_eff));

  assign push               = take && !is_filter;
  assign push_col           = column_count;
  assign push_op.data       = data_byte;
  assign push_op.filter     = row_filter;
  assign push_op.left_ok    = left_ok;
  assign push_op.first_row  = on_first_row;
  assign push_op.row_end    = row_end;

  // Row position state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_filter      <= png_unf_pkg::FILT_NONE;
      awaiting_filter <= 1'b1;
      on_first_row    <= 1'b1;
    end else if (take) begin
      if (is_filter) begin
        row_filter      <= data_byte;
        column_count    <= '0;
        awaiting_filter <= 1'b0;
        if (image_start) begin
          on_first_row <= 1'b1;
        end
      end else if (row_end) begin
        column_count    <= '0;
        awaiting_filter <= 1'b1;
        on_first_row    <= 1'b0;
      end else begin
        column_count <= AW'(col_inc);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/png_unf_back.sv =====
// ----------------------------------------------------------------------------
// png_unf_back
// Back end: reads the byte above from the row store, rebuilds each byte with
// its filter, writes it back to the row store and holds it in the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module png_unf_back #(
  parameter int MAX_ROW_BYTES   = png_unf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = png_unf_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    q_valid,
  input  wire logic [$clog2(MAX_ROW_BYTES)-1:0]        q_col,
  input  wire png_unf_pkg::unf_op_t                    q_op,
  output      logic                                    q_pop,
  input  wire logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] pb_idx,
  output      logic                                    out_valid,
  input  wire logic                                    out_ready,
  output      logic [png_unf_pkg::DATA_W-1:0]          pixel_byte,
  output      logic                                    row_end
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int DW = png_unf_pkg::DATA_W;

  // Reconstruction stage
  logic                 r_valid;
  logic [AW-1:0]        r_col;
  png_unf_pkg::unf_op_t r_op;
  logic                 r_fire;
  logic                 fwd;
  logic [DW-1:0]        fwd_data;
  logic [DW-1:0]        ram_q;

  logic [DW-1:0] left_hist   [MAX_PIXEL_BYTES];
  logic [DW-1:0] upleft_hist [MAX_PIXEL_BYTES];

  logic [DW-1:0] up;
  logic [DW-1:0] left;
  logic [DW-1:0] upleft;
  logic [DW:0]   avg_sum;
  logic [DW-1:0] recon;

  function automatic logic [DW-1:0] paeth(input logic [DW-1:0] a,
                                          input logic [DW-1:0] b,
                                          input logic [DW-1:0] c);
    logic signed [DW+1:0] p;
    logic signed [DW+1:0] da;
    logic signed [DW+1:0] db;
    logic signed [DW+1:0] dc;
    p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
    da = p - $signed({2'b00, a});
    db = p - $signed({2'b00, b});
    dc = p - $signed({2'b00, c});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  assign r_fire = r_valid && (!out_valid || out_ready);
  assign q_pop  = q_valid && (!r_valid || r_fire);

  // Row store, read on pop, written when the byte is rebuilt
  png_unf_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (r_fire),
    .wr_addr (r_col),
    .wr_data (recon),
    .rd_en   (q_pop),
    .rd_addr (q_col),
    .rd_data (ram_q)
  );

  // Neighbour bytes; a write to the same column in the pop cycle is bypassed
  assign up      = r_op.first_row ? '0 : (fwd ? fwd_data : ram_q);
  assign left    = r_op.left_ok ? left_hist[pb_idx] : '0;
  assign upleft  = (r_op.left_ok && !r_op.first_row) ? upleft_hist[pb_idx] : '0;
  assign avg_sum = {1'b0, left} + {1'b0, up};

  always_comb begin
    case (r_op.filter)
      png_unf_pkg::FILT_SUB:   recon = r_op.data + left;
      png_unf_pkg::FILT_UP:    recon = r_op.data + up;
      png_unf_pkg::FILT_AVG:   recon = r_op.data + avg_sum[DW:1];
      png_unf_pkg::FILT_PAETH: recon = r_op.data + paeth(left, up, upleft);
      default:                 recon = r_op.data;
    endcase
  end

  // Stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (q_pop) begin
      r_valid <= 1'b1;
    end else if (r_fire) begin
      r_valid <= 1'b0;
    end
  end

  // Stage payload and bypass
  always_ff @(posedge clk) begin
    if (q_pop) begin
      r_col    <= q_col;
      r_op     <= q_op;
      fwd      <= r_fire && (r_col == q_col);
      fwd_data <= recon;
    end
  end

  // Newest-first histories of rebuilt and above bytes
  always_ff @(posedge clk) begin
    if (r_fire) begin
      left_hist[0]   <= recon;
      upleft_hist[0] <= up;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]   <= left_hist[i-1];
        upleft_hist[i] <= upleft_hist[i-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_fire) begin
      pixel_byte <= recon;
      row_end    <= r_op.row_end;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/png_row_unfilter_core.sv =====
// ----------------------------------------------------------------------------
// png_row_unfilter_core
// PNG scanline reconstruction (None, Sub, Up, Average, Paeth) on a byte
// stream, one byte per clock unless back-pressured.
// ----------------------------------------------------------------------------
// Every row is a filter-type beat followed by row_bytes data beats. The core
// takes one beat per clock unless the queue is full, filter beats included;
// a filter beat gives no output, each data beat gives one registered output
// beat. Unless stalled, the row store does one read of the previous row and
// one write of the current row per clock. A short queue decouples the input
// from output back-pressure. image_start marks the filter beat of row zero.
// Registers: 0 row_bytes (1..MAX_ROW_BYTES), 1 pixel_stride
// (1..MAX_PIXEL_BYTES); write them only while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "png_row_unfilter_core_defines.svh"

module png_row_unfilter_core #(
  parameter int MAX_ROW_BYTES   = png_unf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = png_unf_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [png_unf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [png_unf_pkg::CFG_DATA_W-1:0]    cfg_data,
  png_unf_in_if.sink                                 din,
  png_unf_out_if.source                              dout
);

  localparam int AW  = $clog2(MAX_ROW_BYTES);
  localparam int PIW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int OPW = $bits(png_unf_pkg::unf_op_t);

  logic [png_unf_pkg::ROW_BYTES_W-1:0]    row_bytes;
  logic [png_unf_pkg::PIXEL_STRIDE_W-1:0] pixel_stride;

  logic                 take;
  logic                 q_push;
  logic [AW-1:0]        push_col;
  png_unf_pkg::unf_op_t push_op;
  logic [PIW-1:0]       pb_idx;

  logic                 q_valid;
  logic                 q_full;
  logic                 q_pop;
  logic [AW+OPW-1:0]    q_rdata;
  logic [AW-1:0]        q_col;
  png_unf_pkg::unf_op_t q_op;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes    <= png_unf_pkg::ROW_BYTES_RST;
      pixel_stride <= png_unf_pkg::PIXEL_STRIDE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        png_unf_pkg::REG_ROW_BYTES:    row_bytes    <= cfg_data;
        png_unf_pkg::REG_PIXEL_STRIDE:
          pixel_stride <= cfg_data[png_unf_pkg::PIXEL_STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beat handshake
  assign din.ready = !q_full;
  assign take      = din.valid && din.ready;

  png_unf_front #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .row_bytes    (row_bytes),
    .pixel_stride (pixel_stride),
    .take         (take),
    .data_byte    (din.data_byte),
    .image_start  (din.image_start),
    .push         (q_push),
    .push_col     (push_col),
    .push_op      (push_op),
    .pb_idx       (pb_idx)
  );

  png_unf_fifo #(
    .WIDTH (AW + OPW),
    .DEPTH (png_unf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({push_col, push_op}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid),
    .full  (q_full)
  );

  assign q_col = q_rdata[AW+OPW-1:OPW];
  assign q_op  = q_rdata[OPW-1:0];

  png_unf_back #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_col      (q_col),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .pb_idx     (pb_idx),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .pixel_byte (dout.pixel_byte),
    .row_end    (dout.row_end)
  );

  // Checks
  `PUC_ASSERT(a_start_is_filter, (take && din.image_start) |-> !q_push, "image start beat queued as data")
  `PUC_ASSERT(a_full_has_head, q_full |-> q_valid, "queue full without a head entry")
  `PUC_ASSERT_ALWAYS(a_reset_clean, $fell(rst) |-> (din.ready && !dout.valid), "core not empty after reset")

endmodule

`default_nettype wire
